>>> rtl/core/iucc_pkg.sv
// Shared types and constants of the IPv4 header and UDP checksum calculator.
// No dependencies; front, back and top refer to it by scoped names.
`default_nettype none

package iucc_pkg;

    localparam int unsigned WORD_W = 16;

    // Header layout, in 16-bit words from the start of the IP header
    localparam logic [3:0]  IHL_MIN           = 4'd5;
    localparam logic [4:0]  HDR_WORDS_DEFAULT = 5'd10;
    localparam logic [15:0] IDX_PROTOCOL      = 16'd4;
    localparam logic [15:0] IDX_IP_CSUM       = 16'd5;
    localparam logic [15:0] IDX_ADDR_FIRST    = 16'd6;
    localparam logic [15:0] IDX_ADDR_LAST     = 16'd9;
    localparam logic [15:0] IDX_MAX           = 16'hFFFF;

    // Datagram layout, in words from the start of the UDP header
    localparam logic [15:0] DG_FIRST   = 16'd0;
    localparam logic [15:0] DG_SECOND  = 16'd1;
    localparam logic [15:0] DG_LENGTH  = 16'd2;
    localparam logic [15:0] DG_CSUM    = 16'd3;

    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [15:0] ODD_MASK   = 16'hFF00;

    // One classified beat handed from front to back
    typedef struct packed {
        logic [15:0] ip_term;     // zero when the word is not summed
        logic        ip_seen_wr;
        logic [17:0] udp_part;    // plain sum of this beat's UDP terms
        logic        udp_seen_wr;
        logic [15:0] word;
        logic        proto_wr;
        logic        proto_udp;
        logic        bad_ihl;
        logic        eop;
    } op_t;

    // One finished result
    typedef struct packed {
        logic [15:0] ip_sum_computed;
        logic [15:0] ip_sum_received;
        logic [15:0] udp_sum_computed;
        logic [15:0] udp_sum_received;
        logic        is_udp;
        logic        bad_header_length;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/iucc_fifo.sv
// Small register queue with a count; used between front and back and at the output.
// No package dependencies.
`default_nettype none

module iucc_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/iucc_front.sv
// Front end: tracks the word position in the packet and turns each word into a beat
// of sum terms and capture strobes. Depends on iucc_pkg.
`default_nettype none

module iucc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [15:0]   packet_word,
    input  wire logic          end_of_packet,
    output iucc_pkg::op_t      op
);

    logic [15:0] word_index_reg, word_index_next;
    logic [4:0]  header_words_reg, header_words_next;
    logic [15:0] udp_length_reg, udp_length_next;
    logic [15:0] held_first_reg, held_second_reg;

    logic [3:0]  ihl;
    logic [4:0]  hw;
    logic        in_hdr;
    logic [15:0] d;
    logic [15:0] t_len, t_a, t_b, t_c;

    // Datagram word d contributes only inside the UDP length; odd tail keeps its high byte
    function automatic logic [15:0] dg_term(input logic [15:0] dw, input logic [15:0] w,
                                            input logic [15:0] len);
        logic [16:0] nw17;
        logic [15:0] nw;
        logic [15:0] r;
        nw17 = {1'b0, len} + 17'd1;
        nw   = nw17[16:1];
        if (dw == iucc_pkg::DG_CSUM || dw >= nw)
            r = '0;
        else if (len[0] && dw == nw - 16'd1)
            r = w & iucc_pkg::ODD_MASK;
        else
            r = w;
        return r;
    endfunction

    assign ihl    = packet_word[11:8];
    assign hw     = (word_index_reg != '0) ? header_words_reg :
                    (ihl < iucc_pkg::IHL_MIN) ? iucc_pkg::HDR_WORDS_DEFAULT : {ihl, 1'b0};
    assign in_hdr = word_index_reg < {11'b0, hw};
    assign d      = word_index_reg - {11'b0, hw};

    always_comb
    begin
        t_len = '0;
        t_a   = '0;
        t_b   = '0;
        t_c   = '0;
        op    = '0;
        op.word    = packet_word;
        op.eop     = end_of_packet;
        op.bad_ihl = (word_index_reg == '0) && (ihl < iucc_pkg::IHL_MIN);
        udp_length_next = udp_length_reg;

        if (in_hdr)
        begin
            if (word_index_reg == iucc_pkg::IDX_IP_CSUM)
                op.ip_seen_wr = 1'b1;
            else
                op.ip_term = packet_word;
            if (word_index_reg == iucc_pkg::IDX_PROTOCOL)
            begin
                op.proto_wr  = 1'b1;
                op.proto_udp = (packet_word[7:0] == iucc_pkg::PROTO_UDP);
                t_len        = {8'b0, iucc_pkg::PROTO_UDP};
            end
            if (word_index_reg >= iucc_pkg::IDX_ADDR_FIRST &&
                word_index_reg <= iucc_pkg::IDX_ADDR_LAST)
                t_len = packet_word;
        end
        else if (d == iucc_pkg::DG_LENGTH)
        begin
            // Length known now: release the two held words
            udp_length_next = packet_word;
            t_len = packet_word;
            t_a   = dg_term(iucc_pkg::DG_FIRST, held_first_reg, packet_word);
            t_b   = dg_term(iucc_pkg::DG_SECOND, held_second_reg, packet_word);
            t_c   = dg_term(iucc_pkg::DG_LENGTH, packet_word, packet_word);
        end
        else if (d != iucc_pkg::DG_FIRST && d != iucc_pkg::DG_SECOND)
        begin
            op.udp_seen_wr = (d == iucc_pkg::DG_CSUM);
            t_c = dg_term(d, packet_word, udp_length_reg);
        end

        op.udp_part = {2'b0, t_len} + {2'b0, t_a} + {2'b0, t_b} + {2'b0, t_c};

        // Advance the position up to IDX_MAX, or drop back to the start after the last word
        word_index_next   = (word_index_reg == iucc_pkg::IDX_MAX) ? word_index_reg
                                                                  : word_index_reg + 16'd1;
        header_words_next = hw;
        if (end_of_packet)
        begin
            word_index_next   = '0;
            header_words_next = iucc_pkg::HDR_WORDS_DEFAULT;
            udp_length_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_index_reg   <= '0;
            header_words_reg <= iucc_pkg::HDR_WORDS_DEFAULT;
            udp_length_reg   <= '0;
        end
        else if (accept)
        begin
            word_index_reg   <= word_index_next;
            header_words_reg <= header_words_next;
            udp_length_reg   <= udp_length_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !in_hdr && d == iucc_pkg::DG_FIRST)
            held_first_reg <= packet_word;
        if (accept && !in_hdr && d == iucc_pkg::DG_SECOND)
            held_second_reg <= packet_word;
    end

endmodule

`default_nettype wire

>>> rtl/core/iucc_back.sv
// Back end: folds each beat into the two ones'-complement sums and captures the
// received checksums; emits a result on the last beat. Depends on iucc_pkg.
`default_nettype none

module iucc_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             op_valid,
    input  wire iucc_pkg::op_t    op,
    output logic                  op_pop,
    input  wire logic             res_full,
    output logic                  res_wr,
    output iucc_pkg::result_t     res_data
);

    logic [15:0] ip_acc_reg, ip_acc_next;
    logic [15:0] udp_acc_reg, udp_acc_next;
    logic [15:0] ip_seen_reg, ip_seen_next;
    logic [15:0] udp_seen_reg, udp_seen_next;
    logic        proto_reg, proto_next;
    logic        bad_ihl_reg, bad_ihl_next;

    logic [16:0] ip_s;
    logic [18:0] udp_s;
    logic [16:0] udp_f;

    // Hold a last beat while the result queue is full
    assign op_pop = op_valid && !(op.eop && res_full);
    assign res_wr = op_pop && op.eop;

    always_comb
    begin
        ip_s  = {1'b0, ip_acc_reg} + {1'b0, op.ip_term};
        udp_s = {3'b0, udp_acc_reg} + {1'b0, op.udp_part};
        udp_f = {1'b0, udp_s[15:0]} + {14'b0, udp_s[18:16]};

        ip_acc_next   = ip_s[15:0] + {15'b0, ip_s[16]};
        udp_acc_next  = udp_f[15:0] + {15'b0, udp_f[16]};
        ip_seen_next  = op.ip_seen_wr ? op.word : ip_seen_reg;
        udp_seen_next = op.udp_seen_wr ? op.word : udp_seen_reg;
        proto_next    = op.proto_wr ? op.proto_udp : proto_reg;
        bad_ihl_next  = bad_ihl_reg || op.bad_ihl;

        res_data.ip_sum_computed   = ~ip_acc_next;
        res_data.ip_sum_received   = ip_seen_next;
        res_data.udp_sum_computed  = proto_next ? ~udp_acc_next : '0;
        res_data.udp_sum_received  = proto_next ? udp_seen_next : '0;
        res_data.is_udp            = proto_next;
        res_data.bad_header_length = bad_ihl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_acc_reg   <= '0;
            udp_acc_reg  <= '0;
            ip_seen_reg  <= '0;
            udp_seen_reg <= '0;
            proto_reg    <= 1'b0;
            bad_ihl_reg  <= 1'b0;
        end
        else if (op_pop)
        begin
            if (op.eop)
            begin
                ip_acc_reg   <= '0;
                udp_acc_reg  <= '0;
                ip_seen_reg  <= '0;
                udp_seen_reg <= '0;
                proto_reg    <= 1'b0;
                bad_ihl_reg  <= 1'b0;
            end
            else
            begin
                ip_acc_reg   <= ip_acc_next;
                udp_acc_reg  <= udp_acc_next;
                ip_seen_reg  <= ip_seen_next;
                udp_seen_reg <= udp_seen_next;
                proto_reg    <= proto_next;
                bad_ihl_reg  <= bad_ihl_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ipv4_udp_checksum_calc.sv
// Top level of the IPv4 header and UDP checksum calculator.
// Depends on iucc_pkg, iucc_fifo, iucc_front and iucc_back.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------
//  words in | packet_word, end_of_packet              | push / full
//  results  | ip_sum_computed, ip_sum_received,       | empty / pop
//           | udp_sum_computed, udp_sum_received,     |
//           | is_udp, bad_header_length               |
//
// One word beat is taken every clock while the word queue has room; the back end
// folds a whole beat into both sums per cycle unless a full result queue holds it.
// A result passes through the word queue and then the result queue, each a
// register stage. Reset clears both queues and the packet state but for the two
// held datagram words. A full result queue holds the back end on a last word; the
// word queue (QUEUE_DEPTH deep) then fills and raises full.
`default_nettype none

module ipv4_udp_checksum_calc #(
    parameter int unsigned QUEUE_DEPTH  = 4,
    parameter int unsigned RESULT_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [15:0] packet_word,
    input  wire logic        end_of_packet,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      ip_sum_computed,
    output logic [15:0]      ip_sum_received,
    output logic [15:0]      udp_sum_computed,
    output logic [15:0]      udp_sum_received,
    output logic             is_udp,
    output logic             bad_header_length
);

    localparam int unsigned OP_W  = $bits(iucc_pkg::op_t);
    localparam int unsigned RES_W = $bits(iucc_pkg::result_t);

    logic              accept;
    iucc_pkg::op_t     op_in;
    iucc_pkg::op_t     op_head;
    logic              op_empty;
    logic              op_pop;
    logic              res_full;
    logic              res_wr;
    iucc_pkg::result_t res_in;
    iucc_pkg::result_t res_head;

    assign accept = push && !full;

    // Classify each word as it is taken
    iucc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .packet_word   (packet_word),
        .end_of_packet (end_of_packet),
        .op            (op_in)
    );

    // Decouple the front from a back end held by a full result queue
    iucc_fifo #(
        .WIDTH (OP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_op_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (op_in),
        .full    (full),
        .rd_en   (op_pop),
        .rd_data (op_head),
        .empty   (op_empty)
    );

    iucc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (!op_empty),
        .op       (op_head),
        .op_pop   (op_pop),
        .res_full (res_full),
        .res_wr   (res_wr),
        .res_data (res_in)
    );

    // Hold finished results until the consumer pops them
    iucc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RESULT_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_head),
        .empty   (empty)
    );

    assign ip_sum_computed   = res_head.ip_sum_computed;
    assign ip_sum_received   = res_head.ip_sum_received;
    assign udp_sum_computed  = res_head.udp_sum_computed;
    assign udp_sum_received  = res_head.udp_sum_received;
    assign is_udp            = res_head.is_udp;
    assign bad_header_length = res_head.bad_header_length;

    // A last word consumed by the back end leaves a result waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (op_pop && op_head.eop) |=> !empty)
        else $error("result missing after last word");

    // Never write the result queue while it is full
    assert property (@(posedge clk) disable iff (!rst_n)
        res_wr |-> !res_full)
        else $error("result queue overflow");

    // UDP fields read zero on a non-UDP result
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !is_udp) |-> (udp_sum_computed == '0 && udp_sum_received == '0))
        else $error("UDP fields set on non-UDP packet");

endmodule

`default_nettype wire

>>> dv/iucc_result_checker.sv
// Result checker for the IPv4 header and UDP checksum calculator.
// Watches both queue channels, predicts each packet's sums, compares field by field.
// Depends on iucc_pkg for the header layout constants and the result type.
module iucc_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [15:0] packet_word,
    input  logic        end_of_packet,
    input  logic        empty,
    input  logic        pop,
    input  logic [15:0] ip_sum_computed,
    input  logic [15:0] ip_sum_received,
    input  logic [15:0] udp_sum_computed,
    input  logic [15:0] udp_sum_received,
    input  logic        is_udp,
    input  logic        bad_header_length,
    output int          failures,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Per-packet state of the prediction
    logic [15:0] pos;
    logic [4:0]  hdr_len;
    logic [15:0] ip_acc;
    logic [15:0] udp_acc;
    logic [15:0] ip_csum_rx;
    logic [15:0] udp_csum_rx;
    logic [15:0] dg_len;
    logic        proto_udp;
    logic        ihl_bad;
    logic [15:0] dg_word0;
    logic [15:0] dg_word1;

    iucc_pkg::result_t sums_due[$];

    initial failures = 0;

    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    task automatic clear_packet();
        pos         = '0;
        hdr_len     = iucc_pkg::HDR_WORDS_DEFAULT;
        ip_acc      = '0;
        udp_acc     = '0;
        ip_csum_rx  = '0;
        udp_csum_rx = '0;
        dg_len      = '0;
        proto_udp   = 1'b0;
        ihl_bad     = 1'b0;
        dg_word0    = '0;
        dg_word1    = '0;
    endtask

    // Add datagram word d, bounded by the UDP length; zero the pad byte of an odd tail
    task automatic add_dg_word(input logic [15:0] d, input logic [15:0] w);
        logic [16:0] n_words;
        logic [15:0] v;
        n_words = ({1'b0, dg_len} + 17'd1) >> 1;
        v = w;
        if (d != iucc_pkg::DG_CSUM && {1'b0, d} < n_words) begin
            if (dg_len[0] && {1'b0, d} == n_words - 17'd1)
                v = v & iucc_pkg::ODD_MASK;
            udp_acc = fold_add(udp_acc, v);
        end
    endtask

    task automatic absorb_word(input logic [15:0] w, input logic last);
        logic [3:0]        ihl;
        logic [15:0]       d;
        iucc_pkg::result_t r;
        if (pos == 16'd0) begin
            ihl = w[11:8];
            if (ihl < iucc_pkg::IHL_MIN) begin
                ihl_bad = 1'b1;
                hdr_len = iucc_pkg::HDR_WORDS_DEFAULT;
            end else begin
                hdr_len = {ihl, 1'b0};
            end
        end
        if (pos < {11'd0, hdr_len}) begin
            if (pos == iucc_pkg::IDX_IP_CSUM)
                ip_csum_rx = w;
            else
                ip_acc = fold_add(ip_acc, w);
            if (pos == iucc_pkg::IDX_PROTOCOL) begin
                proto_udp = (w[7:0] == iucc_pkg::PROTO_UDP);
                udp_acc   = fold_add(udp_acc, {8'h00, iucc_pkg::PROTO_UDP});
            end
            if (pos >= iucc_pkg::IDX_ADDR_FIRST && pos <= iucc_pkg::IDX_ADDR_LAST)
                udp_acc = fold_add(udp_acc, w);
        end else begin
            d = pos - {11'd0, hdr_len};
            if (d == iucc_pkg::DG_FIRST) begin
                dg_word0 = w;
            end else if (d == iucc_pkg::DG_SECOND) begin
                dg_word1 = w;
            end else if (d == iucc_pkg::DG_LENGTH) begin
                dg_len  = w;
                udp_acc = fold_add(udp_acc, w);
                add_dg_word(iucc_pkg::DG_FIRST, dg_word0);
                add_dg_word(iucc_pkg::DG_SECOND, dg_word1);
                add_dg_word(iucc_pkg::DG_LENGTH, w);
            end else begin
                if (d == iucc_pkg::DG_CSUM)
                    udp_csum_rx = w;
                add_dg_word(d, w);
            end
        end
        if (pos != iucc_pkg::IDX_MAX)
            pos = pos + 16'd1;
        if (last) begin
            r.ip_sum_computed   = ~ip_acc;
            r.ip_sum_received   = ip_csum_rx;
            r.udp_sum_computed  = proto_udp ? ~udp_acc : 16'h0000;
            r.udp_sum_received  = proto_udp ? udp_csum_rx : 16'h0000;
            r.is_udp            = proto_udp;
            r.bad_header_length = ihl_bad;
            sums_due.push_back(r);
            clear_packet();
        end
    endtask

    // Count every mismatch and print one line for it
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        failures++;
        $display("%0t ns: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic check_result();
        iucc_pkg::result_t want;
        if (sums_due.size() == 0) begin
            report_mismatch("result beat with no packet pending", ip_sum_computed, 16'h0000);
        end else begin
            want = sums_due.pop_front();
            check_field("ip_sum_computed", ip_sum_computed, want.ip_sum_computed);
            check_field("ip_sum_received", ip_sum_received, want.ip_sum_received);
            check_field("udp_sum_computed", udp_sum_computed, want.udp_sum_computed);
            check_field("udp_sum_received", udp_sum_received, want.udp_sum_received);
            check_field("is_udp", {15'd0, is_udp}, {15'd0, want.is_udp});
            check_field("bad_header_length", {15'd0, bad_header_length},
                        {15'd0, want.bad_header_length});
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_packet();
            sums_due.delete();
            outstanding <= 0;
        end else begin
            if (pop && !empty)
                check_result();
            if (push && !full)
                absorb_word(packet_word, end_of_packet);
            outstanding <= sums_due.size();
        end
    end

endmodule

>>> dv/testbench.sv
// Top of the checksum calculator testbench: clock, reset, packet stimulus and verdict.
// Depends on iucc_pkg, the ipv4_udp_checksum_calc RTL and iucc_result_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // A generous ceiling on the run
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_DG_WORDS = 24;

    typedef enum int {
        PKT_UDP,
        PKT_OTHER_PROTO,
        PKT_BAD_IHL,
        PKT_TRUNCATED,
        PKT_NOISE
    } pkt_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [15:0] packet_word = '0;
    logic        end_of_packet = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] ip_sum_computed;
    logic [15:0] ip_sum_received;
    logic [15:0] udp_sum_computed;
    logic [15:0] udp_sum_received;
    logic        is_udp;
    logic        bad_header_length;

    int failures;
    int outstanding;

    // Idle rates of the two sides, in percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    logic hold_request = 1'b0;
    logic hold_results = 1'b0;
    int   cycles = 0;

    // Words of the packet being assembled
    logic [15:0] frame[$];

    int phase_words;
    int phase_packets;

    always #2 clk = ~clk;

    ipv4_udp_checksum_calc i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .packet_word       (packet_word),
        .end_of_packet     (end_of_packet),
        .empty             (empty),
        .pop               (pop),
        .ip_sum_computed   (ip_sum_computed),
        .ip_sum_received   (ip_sum_received),
        .udp_sum_computed  (udp_sum_computed),
        .udp_sum_received  (udp_sum_received),
        .is_udp            (is_udp),
        .bad_header_length (bad_header_length)
    );

    iucc_result_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .packet_word       (packet_word),
        .end_of_packet     (end_of_packet),
        .empty             (empty),
        .pop               (pop),
        .ip_sum_computed   (ip_sum_computed),
        .ip_sum_received   (ip_sum_received),
        .udp_sum_computed  (udp_sum_computed),
        .udp_sum_received  (udp_sum_received),
        .is_udp            (is_udp),
        .bad_header_length (bad_header_length),
        .failures          (failures),
        .outstanding       (outstanding)
    );

    // Receiver: take a result beat unless stalling at random or held off
    always @(posedge clk)
        pop <= !hold_results && ($urandom_range(99) >= recv_stall_pct);

    // Long receiver hold-off, counted here so the sender keeps offering words meanwhile
    initial begin
        wait (hold_request);
        @(posedge clk);
        hold_results <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] rand_word();
        logic [31:0] r;
        r = $urandom();
        return r[15:0];
    endfunction

    // Offer one word beat, idling first at the sender's rate; return at the accepting edge.
    // Within a beat, push is only lowered on an idle cycle, so each step carries one update to it.
    task automatic send_beat(input logic [15:0] w, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push          <= 1'b1;
        packet_word   <= w;
        end_of_packet <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame.size(); i++)
            send_beat(frame[i], i == frame.size() - 1);
        phase_words   += frame.size();
        phase_packets += 1;
    endtask

    // Assemble a packet: random header with the given IHL and protocol byte, then
    // dg_count datagram words with the length field at its place
    task automatic build_packet(input logic [3:0] ihl, input logic [7:0] proto,
                                input logic [15:0] dg_len, input int dg_count);
        int          hdr;
        int          i;
        logic [15:0] w;
        frame.delete();
        hdr = (ihl < iucc_pkg::IHL_MIN) ? int'(iucc_pkg::HDR_WORDS_DEFAULT) : 2 * int'(ihl);
        for (i = 0; i < hdr; i++) begin
            w = rand_word();
            if (i == 0)
                w[11:8] = ihl;
            if (i == int'(iucc_pkg::IDX_PROTOCOL))
                w[7:0] = proto;
            frame.push_back(w);
        end
        for (i = 0; i < dg_count; i++) begin
            w = rand_word();
            if (i == int'(iucc_pkg::DG_LENGTH))
                w = dg_len;
            frame.push_back(w);
        end
    endtask

    // Mostly well-formed UDP packets with random content; the rest are other protocols,
    // undersized IHL, packets cut off early and plain noise
    task automatic send_random_packet();
        int          pick;
        int          n_dg;
        int          i;
        int          keep;
        pkt_kind_t   kind;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] len;
        pick = $urandom_range(99);
        kind = (pick < 55) ? PKT_UDP :
               (pick < 65) ? PKT_OTHER_PROTO :
               (pick < 75) ? PKT_BAD_IHL :
               (pick < 88) ? PKT_TRUNCATED : PKT_NOISE;
        ihl   = ($urandom_range(99) < 70) ? iucc_pkg::IHL_MIN : 4'($urandom_range(15, 6));
        proto = iucc_pkg::PROTO_UDP;
        len   = 16'($urandom_range(40, 8));
        // Occasionally a length below the UDP header or far beyond the words sent
        if ($urandom_range(9) == 0)
            len = 16'($urandom_range(7, 0));
        else if ($urandom_range(14) == 0)
            len = rand_word();
        n_dg = (int'(len) + 1) / 2;
        // Trailing words past the length bound
        if ($urandom_range(4) == 0)
            n_dg += $urandom_range(3, 1);
        if (n_dg < 4)
            n_dg = 4;
        if (n_dg > MAX_DG_WORDS)
            n_dg = MAX_DG_WORDS;
        unique case (kind)
            PKT_OTHER_PROTO: begin
                proto = 8'($urandom_range(255));
                if (proto == iucc_pkg::PROTO_UDP)
                    proto = ~iucc_pkg::PROTO_UDP;
                build_packet(ihl, proto, len, n_dg);
            end
            PKT_BAD_IHL:
                build_packet(4'($urandom_range(4, 0)), proto, len, n_dg);
            PKT_TRUNCATED: begin
                build_packet(4'($urandom_range(15)), proto, len, n_dg);
                keep = $urandom_range(14, 1);
                while (frame.size() > keep)
                    void'(frame.pop_back());
            end
            PKT_NOISE: begin
                frame.delete();
                keep = $urandom_range(30, 1);
                for (i = 0; i < keep; i++)
                    frame.push_back(rand_word());
            end
            default:
                build_packet(ihl, proto, len, n_dg);
        endcase
        send_frame();
    endtask

    // Lower push and wait until every expected result has been taken
    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    initial begin
        int          phase;
        int          i;
        int          idle_tab[4];
        int          stall_tab[4];
        idle_tab  = '{0, 58, 0, 9};
        stall_tab = '{0, 0, 58, 9};
        phase_words   = 0;
        phase_packets = 0;

        // Reset once, released on a clock edge
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-word packets at both IHL extremes (the zero one is undersized)
        frame = '{16'hFFFF};
        send_frame();
        frame = '{16'h0000};
        send_frame();
        // Minimal UDP packet, 8-byte datagram, checksum words set to all-ones
        frame = '{16'h4500, 16'h001C, 16'h0000, 16'h4000, 16'h4011, 16'hFFFF,
                  16'hC0A8, 16'h0001, 16'hC0A8, 16'h00FF,
                  16'h1F90, 16'h0035, 16'h0008, 16'hFFFF};
        send_frame();
        // Non-UDP packet that ends inside a 30-word header, right after the checksum word
        frame = '{16'h4F00, 16'hFFFF, 16'h0000, 16'h8000, 16'h00FE, 16'h1234};
        send_frame();
        drain_results();

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct  = idle_tab[phase];
            recv_stall_pct = stall_tab[phase];
            phase_words    = 0;
            phase_packets  = 0;
            while (phase_words < 75 || phase_packets < 3)
                send_random_packet();
            if (phase == 0) begin
                // Hold off the receiver and keep short packets coming at full rate so the
                // result queue, then the word queue, fill and full rises
                hold_request = 1'b1;
                for (i = 0; i < 8; i++) begin
                    if (i % 2 == 0) begin
                        frame = '{rand_word()};
                        send_frame();
                    end else begin
                        send_random_packet();
                    end
                end
            end
            // Sender pauses until the receiver has caught up
            drain_results();
        end

        // Let any stray result surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
